FILE: hw/rtl/negative_cycle_finder_macros.svh
// Assertion macros for the negative cycle finder.
`ifndef NEGATIVE_CYCLE_FINDER_MACROS_SVH
`define NEGATIVE_CYCLE_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define NCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define NCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/ncf_pkg.sv
// Shared types and constants of the negative cycle finder.
`default_nettype none
package ncf_pkg;
    localparam int NODES_DEF = 32;
    localparam int EDGES_DEF = 256;
    localparam int NODE_W    = 6;
    localparam int WEIGHT_W  = 32;
    localparam int DIST_W    = 64;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic [WEIGHT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] node_count;
    } t_run_req;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [NODE_W-1:0] node;
        logic              last;
    } t_result;
endpackage
`default_nettype wire

FILE: hw/rtl/ncf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ncf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then read with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ncf_engine.sv
// Search engine: relaxation rounds, flagging, depth-first search, cycle output.
`default_nettype none
module ncf_engine #(
    parameter int NODES = ncf_pkg::NODES_DEF,
    parameter int EDGES = ncf_pkg::EDGES_DEF,
    localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1,
    localparam int ECW = $clog2(EDGES + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ncf_pkg::t_run_req i_req,
    input  wire logic [ECW-1:0]    i_loaded,
    output logic      [EAW-1:0]    o_edge_raddr,
    input  wire ncf_pkg::t_edge    i_edge_q,
    output logic                   o_busy,
    output ncf_pkg::t_result       o_res
);
    import ncf_pkg::*;

    localparam int NDEPTH = NODES + 1;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int SPW    = $clog2(NODES + 2);
    localparam int SW     = NODE_W + ECW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EREAD, ST_EDATA, ST_DU, ST_DV, ST_CMP, ST_POP, ST_NEXTU,
        ST_DONE, ST_PWALK, ST_HEAD, ST_BODY, ST_TAIL, ST_NONE
    } t_state;

    typedef enum logic [1:0] {PH_RELAX, PH_FLAG, PH_SEARCH} t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [NODE_W-1:0]   r_nc;
    logic [NODE_W-1:0]   r_round;
    logic [NODE_W:0]     r_u;
    logic [ECW-1:0]      r_e;
    logic [NODE_W-1:0]   r_src;
    logic [NODE_W-1:0]   r_dst;
    logic [WEIGHT_W-1:0] r_w;
    logic [DIST_W-1:0]   r_du;
    logic [DIST_W-1:0]   r_dv;
    logic [DIST_W-1:0]   r_cand;
    logic                r_dq_ok;
    logic [NODE_W-1:0]   r_top;
    logic [SPW-1:0]      r_sp;
    logic [NAW-1:0]      r_steps;
    logic [NDEPTH-1:0]   r_dvalid;
    logic [NDEPTH-1:0]   r_pvalid;
    logic [NDEPTH-1:0]   r_flag;
    t_result             r_res;

    logic [NODE_W-1:0] n_nc;
    logic [NODE_W-1:0] key;
    logic              usable;
    logic              hit;
    logic              e_end;
    logic              better;
    logic              take;
    logic              push_ok;
    logic              walk_go;
    logic [DIST_W-1:0] dist_val;

    logic              dist_we;
    logic [NAW-1:0]    dist_raddr;
    logic [DIST_W-1:0] dist_q;
    logic              par_we;
    logic [NAW-1:0]    par_raddr;
    logic [NODE_W-1:0] par_q;
    logic              stk_we;
    logic [NAW-1:0]    stk_waddr;
    logic [SW-1:0]     stk_wdata;
    logic [NAW-1:0]    stk_raddr;
    logic [SW-1:0]     stk_q;

    // Clamp the node count into 1..NODES
    always_comb begin
        if (i_req.node_count == '0) begin
            n_nc = NODE_W'(1);
        end else if (i_req.node_count > NODE_W'(NODES)) begin
            n_nc = NODE_W'(NODES);
        end else begin
            n_nc = i_req.node_count;
        end
    end

    // Decode the edge beat and the compare
    assign key     = (r_phase == PH_RELAX) ? r_u[NODE_W-1:0] : r_top;
    assign usable  = (i_edge_q.src != '0) && (i_edge_q.src <= r_nc) &&
                     (i_edge_q.dst != '0) && (i_edge_q.dst <= r_nc);
    assign hit     = usable && ((r_phase == PH_FLAG) || (i_edge_q.src == key));
    assign e_end   = (r_e == i_loaded);
    assign better  = $signed(r_dv) > $signed(r_cand);
    assign take    = better && !r_pvalid[r_dst[NAW-1:0]];
    assign push_ok = r_sp < SPW'(NDEPTH);
    assign walk_go = (par_q != r_u[NODE_W-1:0]) &&
                     ((NODE_W'(r_steps) + NODE_W'(1)) < r_nc);
    assign dist_val = r_dq_ok ? dist_q : '0;

    assign o_edge_raddr = r_e[EAW-1:0];

    // Drive memory ports from the current state
    always_comb begin
        dist_raddr = '0;
        dist_we    = 1'b0;
        par_raddr  = '0;
        par_we     = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;
        case (r_state)
            ST_EDATA: begin
                if (hit) begin
                    dist_raddr = i_edge_q.src[NAW-1:0];
                end
            end
            ST_DU: begin
                dist_raddr = r_dst[NAW-1:0];
            end
            ST_CMP: begin
                if (r_phase == PH_RELAX) begin
                    dist_we = better;
                end else if (r_phase == PH_SEARCH) begin
                    dist_we = take;
                    par_we  = take;
                    if (take && push_ok) begin
                        stk_we    = 1'b1;
                        stk_waddr = NAW'(r_sp - SPW'(1));
                        stk_wdata = {r_top, ECW'(r_e + ECW'(1))};
                    end
                end
            end
            ST_EREAD: begin
                if (e_end && r_phase == PH_SEARCH && r_sp > SPW'(1)) begin
                    stk_raddr = NAW'(r_sp - SPW'(2));
                end
            end
            ST_DONE: begin
                par_raddr = r_u[NAW-1:0];
            end
            ST_PWALK: begin
                if (walk_go) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_steps;
                    stk_wdata = {par_q, ECW'(0)};
                    par_raddr = par_q[NAW-1:0];
                end
            end
            ST_HEAD, ST_BODY: begin
                if (r_steps != '0) begin
                    stk_raddr = r_steps - NAW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequence the run and hold registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_RELAX;
            r_res    <= '0;
            r_dvalid <= '0;
            r_pvalid <= '0;
            r_flag   <= '0;
            r_sp     <= '0;
        end else begin
            r_res.valid <= 1'b0;
            r_dq_ok     <= r_dvalid[dist_raddr];
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_nc     <= n_nc;
                        r_dvalid <= '0;
                        r_pvalid <= '0;
                        r_flag   <= '0;
                        r_round  <= '0;
                        r_u      <= (NODE_W+1)'(1);
                        r_e      <= '0;
                        r_phase  <= PH_RELAX;
                        r_state  <= ST_EREAD;
                    end
                end
                ST_EREAD: begin
                    if (!e_end) begin
                        r_state <= ST_EDATA;
                    end else begin
                        case (r_phase)
                            PH_RELAX: begin
                                r_e <= '0;
                                if (r_u[NODE_W-1:0] == r_nc) begin
                                    r_u <= (NODE_W+1)'(1);
                                    if (r_round == r_nc - NODE_W'(1)) begin
                                        r_phase <= PH_FLAG;
                                    end else begin
                                        r_round <= r_round + NODE_W'(1);
                                    end
                                end else begin
                                    r_u <= r_u + (NODE_W+1)'(1);
                                end
                            end
                            PH_FLAG: begin
                                r_u     <= (NODE_W+1)'(1);
                                r_state <= ST_NEXTU;
                            end
                            default: begin
                                // pop the finished node
                                r_sp <= r_sp - SPW'(1);
                                if (r_sp == SPW'(1)) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_POP;
                                end
                            end
                        endcase
                    end
                end
                ST_POP: begin
                    r_top   <= stk_q[SW-1:ECW];
                    r_e     <= stk_q[ECW-1:0];
                    r_state <= ST_EREAD;
                end
                ST_EDATA: begin
                    if (hit) begin
                        r_src   <= i_edge_q.src;
                        r_dst   <= i_edge_q.dst;
                        r_w     <= i_edge_q.weight;
                        r_state <= ST_DU;
                    end else begin
                        r_e     <= r_e + ECW'(1);
                        r_state <= ST_EREAD;
                    end
                end
                ST_DU: begin
                    r_du    <= dist_val;
                    r_state <= ST_DV;
                end
                ST_DV: begin
                    r_dv    <= dist_val;
                    r_cand  <= r_du + {{(DIST_W-WEIGHT_W){r_w[WEIGHT_W-1]}}, r_w};
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_state <= ST_EREAD;
                    r_e     <= r_e + ECW'(1);
                    case (r_phase)
                        PH_RELAX: begin
                            if (better) begin
                                r_dvalid[r_dst[NAW-1:0]] <= 1'b1;
                            end
                        end
                        PH_FLAG: begin
                            if (better) begin
                                r_flag[r_src[NAW-1:0]] <= 1'b1;
                            end
                        end
                        default: begin
                            if (take) begin
                                r_dvalid[r_dst[NAW-1:0]] <= 1'b1;
                                r_pvalid[r_dst[NAW-1:0]] <= 1'b1;
                                if (push_ok) begin
                                    r_top <= r_dst;
                                    r_e   <= '0;
                                    r_sp  <= r_sp + SPW'(1);
                                end
                            end
                        end
                    endcase
                end
                ST_NEXTU: begin
                    if (r_u > {1'b0, r_nc}) begin
                        r_state <= ST_NONE;
                    end else if (!r_flag[r_u[NAW-1:0]]) begin
                        r_u <= r_u + (NODE_W+1)'(1);
                    end else begin
                        r_pvalid <= '0;
                        r_sp     <= SPW'(1);
                        r_top    <= r_u[NODE_W-1:0];
                        r_e      <= '0;
                        r_phase  <= PH_SEARCH;
                        r_state  <= ST_EREAD;
                    end
                end
                ST_DONE: begin
                    if (r_pvalid[r_u[NAW-1:0]]) begin
                        r_steps <= '0;
                        r_state <= ST_PWALK;
                    end else begin
                        r_u     <= r_u + (NODE_W+1)'(1);
                        r_state <= ST_NEXTU;
                    end
                end
                ST_PWALK: begin
                    if (walk_go) begin
                        r_steps <= r_steps + NAW'(1);
                        if (!r_pvalid[par_q[NAW-1:0]]) begin
                            r_state <= ST_HEAD;
                        end
                    end else begin
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    r_res <= '{valid: 1'b1, found: 1'b1, node: r_u[NODE_W-1:0], last: 1'b0};
                    if (r_steps != '0) begin
                        r_steps <= r_steps - NAW'(1);
                        r_state <= ST_BODY;
                    end else begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_BODY: begin
                    r_res <= '{valid: 1'b1, found: 1'b1, node: stk_q[SW-1:ECW], last: 1'b0};
                    if (r_steps != '0) begin
                        r_steps <= r_steps - NAW'(1);
                    end else begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    r_res   <= '{valid: 1'b1, found: 1'b1, node: r_u[NODE_W-1:0], last: 1'b1};
                    r_state <= ST_IDLE;
                end
                ST_NONE: begin
                    r_res   <= '{valid: 1'b1, found: 1'b0, node: '0, last: 1'b1};
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_res  = r_res;

    // Node distances
    ncf_ram #(.WIDTH(DIST_W), .DEPTH(NDEPTH)) u_dist (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (r_dst[NAW-1:0]),
        .i_wdata (r_cand),
        .i_raddr (dist_raddr),
        .o_rdata (dist_q)
    );

    // Search parents
    ncf_ram #(.WIDTH(NODE_W), .DEPTH(NDEPTH)) u_parent (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (r_dst[NAW-1:0]),
        .i_wdata (r_top),
        .i_raddr (par_raddr),
        .o_rdata (par_q)
    );

    // Search stack, reused for the cycle chain
    ncf_ram #(.WIDTH(SW), .DEPTH(NDEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/negative_cycle_finder.sv
// Negative cycle finder top level: config register, edge store, search engine.
//
// Load and clear commands take one cycle and busy stays low, so edges may be
// loaded back to back. A run command raises busy for the whole search. With n
// nodes in use, each scan of the edge store reads every loaded edge, and the
// distances of each edge that is examined, all through the single read port
// of the distance memory; the relaxation pass scans the store n*n times, the
// flag pass once, and each depth-first search about once per visited node.
// Results come out one per cycle with o_valid high for one cycle each; the
// receiver must take them as they come.
`default_nettype none
module negative_cycle_finder #(
    parameter int NODES = ncf_pkg::NODES_DEF,
    parameter int EDGES = ncf_pkg::EDGES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ncf_pkg::NODE_W-1:0]     i_cfg_wdata,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ncf_pkg::CMD_W-1:0]      i_command,
    input  wire logic [ncf_pkg::NODE_W-1:0]     i_edge_from,
    input  wire logic [ncf_pkg::NODE_W-1:0]     i_edge_to,
    input  wire logic signed [ncf_pkg::WEIGHT_W-1:0] i_edge_weight,
    output logic                                o_valid,
    output logic                                o_cycle_found,
    output logic      [ncf_pkg::NODE_W-1:0]     o_cycle_node,
    output logic                                o_last,
    output logic                                o_overflow
);
    import ncf_pkg::*;

    localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECW = $clog2(EDGES + 1);

    logic [NODE_W-1:0] r_node_count;
    logic [ECW-1:0]    r_loaded;
    logic              r_ovf;
    logic              accept;
    logic              store_we;
    logic              full;
    t_edge             edge_wdata;
    t_edge             edge_q;
    logic [EAW-1:0]    edge_raddr;
    t_run_req          req;
    t_result           res;

    assign accept     = start && !busy;
    assign full       = (r_loaded == ECW'(EDGES));
    assign store_we   = accept && (i_command == CMD_LOAD) && !full;
    assign edge_wdata = '{src: i_edge_from, dst: i_edge_to, weight: i_edge_weight};
    assign req        = '{start: accept && (i_command == CMD_RUN), node_count: r_node_count};

    // Hold the node count, the fill count and the sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(1);
            r_loaded     <= '0;
            r_ovf        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (accept) begin
                case (i_command)
                    CMD_LOAD: begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_loaded <= r_loaded + ECW'(1);
                        end
                    end
                    CMD_CLEAR: begin
                        r_loaded <= '0;
                        r_ovf    <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Edge store
    ncf_ram #(.WIDTH($bits(t_edge)), .DEPTH(EDGES)) u_edges (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_loaded[EAW-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q)
    );

    ncf_engine #(.NODES(NODES), .EDGES(EDGES)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_loaded     (r_loaded),
        .o_edge_raddr (edge_raddr),
        .i_edge_q     (edge_q),
        .o_busy       (busy),
        .o_res        (res)
    );

    assign o_valid       = res.valid;
    assign o_cycle_found = res.found;
    assign o_cycle_node  = res.node;
    assign o_last        = res.last;
    assign o_overflow    = r_ovf;

`include "negative_cycle_finder_macros.svh"

    `NCF_ASSERT_NXT(a_run_busy, i_clk, i_rst_n, accept && i_command == CMD_RUN, busy, "run not started")
    `NCF_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, accept && i_command != CMD_RUN, !busy, "load held busy")
    `NCF_ASSERT_IMP(a_none_last, i_clk, i_rst_n, o_valid && !o_cycle_found, o_last, "no-cycle not last")
    `NCF_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last, !o_valid, "beat after last")
endmodule
`default_nettype wire
